>>> rtl/pds_pkg.sv
package pds_pkg;

  // search range
  localparam int unsigned FB_LOW      = 160;
  localparam int unsigned FB_HIGH     = 239;
  localparam int unsigned POSTDIV_MAX = 7;

  // field widths
  localparam int unsigned REF_W    = 7;
  localparam int unsigned TGT_W    = 18;
  localparam int unsigned FBO_W    = 8;
  localparam int unsigned PDO_W    = 3;
  localparam int unsigned FREQ_W   = 19;
  localparam int unsigned REF_RST  = 25;
  localparam int unsigned REF_MAXV = (1 << REF_W) - 1;

  // internal widths
  localparam int unsigned FB_W   = $clog2(FB_HIGH + 1);
  localparam int unsigned PD_W   = $clog2(POSTDIV_MAX + 1);
  localparam int unsigned BASE_W = REF_W + 4;
  localparam int unsigned NUM_W  = $clog2(16 * REF_MAXV * FB_HIGH + 1);
  localparam int unsigned D_W    = 2 * PD_W;
  localparam int unsigned D_N    = 1 << D_W;
  localparam int unsigned SHIFT  = NUM_W + D_W;
  localparam int unsigned RCP_W  = SHIFT + 1;
  localparam int unsigned PROD_W = NUM_W + RCP_W;
  localparam bit          EMPTY_RANGE = (FB_LOW > FB_HIGH);

  // stream word widths
  localparam int unsigned IN_DW  = ((TGT_W + 7) / 8) * 8;
  localparam int unsigned RES_W  = FBO_W + 2 * PDO_W + FREQ_W;
  localparam int unsigned OUT_DW = ((RES_W + 7) / 8) * 8;

  // configuration port
  localparam int unsigned CFG_AW      = 3;
  localparam logic [CFG_AW-1:0] REG_REF_CLK = 3'd0;

endpackage

>>> rtl/pll_divider_search_unit.sv
// pll divider search: an 18-bit target frequency word (1/16 MHz units) starts an
// exhaustive search over feedback dividers 160..239, first post divider 1..7 and
// second post divider 1..7 in ascending order; the first candidate with the smallest
// |floor(16*ref*fb/(pd1*pd2)) - target| wins and is returned as one result word.
// one candidate is evaluated per cycle through a single shared multiplier that
// forms the quotient as numerator times a reciprocal of pd1*pd2 from a constant table,
// so one word runs through 3920 candidates; the stage 1 and stage 2 registers then
// drain into the running best before the result load, and the next word can be
// accepted in the cycle after the result load.
// in_tready is low for the whole search; a finished result sits in the output
// register and the next word is taken while it waits to be read; a search that ends
// while that register is still full holds its result until the register is read.
// the user must write ref_clock_mhz at apb byte address 0 only while idle, unchecked.
module pll_divider_search_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pds_pkg::IN_DW-1:0]     in_tdata,   // [17:0] target_freq
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pds_pkg::OUT_DW-1:0]    out_tdata,  // [7:0] feedback_divider,
                                                    // [10:8] postdiv_first,
                                                    // [13:11] postdiv_second,
                                                    // [32:14] output frequency
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pds_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  localparam int unsigned NW = pds_pkg::NUM_W;
  localparam int unsigned FW = pds_pkg::FB_W;
  localparam int unsigned PW = pds_pkg::PD_W;

  // reciprocal table: ceil(2^SHIFT / d), exact floor for every numerator in range
  logic [pds_pkg::RCP_W-1:0] rcp_tab [pds_pkg::D_N];

  for (genvar g = 0; g < pds_pkg::D_N; g++) begin : g_rcp
    localparam longint unsigned RCP_V =
      ((64'd1 << pds_pkg::SHIFT) + 64'(g) - 64'd1) / ((g == 0) ? 64'd1 : 64'(g));
    assign rcp_tab[g] = pds_pkg::RCP_W'(RCP_V);
  end

  // configuration register
  logic [pds_pkg::REF_W-1:0] ref_r;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == pds_pkg::REG_REF_CLK);
  assign cfg_prdata = (cfg_paddr == pds_pkg::REG_REF_CLK) ? 32'(ref_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= pds_pkg::REF_W'(pds_pkg::REF_RST);
    end else if (cfg_wr) begin
      ref_r <= cfg_pwdata[pds_pkg::REF_W-1:0];
    end
  end

  // sequencer and candidate counters
  logic [1:0]                      state_r, state_nxt;
  logic [FW-1:0]                   fb_r;
  logic [PW-1:0]                   p1_r, p2_r;
  logic [NW-1:0]                   num_r;
  logic [pds_pkg::TGT_W-1:0]       tgt_r;
  logic [pds_pkg::BASE_W-1:0]      base;
  logic                            in_acc, issue, last_cand;
  logic                            out_free;

  assign base      = {ref_r, 4'b0000};
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign issue     = (state_r == ST_RUN);
  assign last_cand = (fb_r == FW'(pds_pkg::FB_HIGH)) &&
                     (p1_r == PW'(pds_pkg::POSTDIV_MAX)) &&
                     (p2_r == PW'(pds_pkg::POSTDIV_MAX));
  assign out_free  = !out_tvalid || out_tready;

  // shared multiplier: numerator times reciprocal of pd1*pd2
  logic [2*PW-1:0]           dsor;
  logic [pds_pkg::RCP_W-1:0] rcp;
  logic [pds_pkg::PROD_W-1:0] prod;

  assign dsor = (2*PW)'(p1_r) * (2*PW)'(p2_r);
  assign rcp  = rcp_tab[dsor[pds_pkg::D_W-1:0]];
  assign prod = pds_pkg::PROD_W'(num_r) * pds_pkg::PROD_W'(rcp);

  // stage 1: product
  logic                       s1_vld_r, s1_last_r;
  logic [pds_pkg::PROD_W-1:0] s1_prod_r;
  logic [FW-1:0]              s1_fb_r;
  logic [PW-1:0]              s1_p1_r, s1_p2_r;

  // stage 2: quotient and error
  logic                       s2_vld_r, s2_last_r;
  logic [NW-1:0]              s2_q_r, s2_err_r;
  logic [FW-1:0]              s2_fb_r;
  logic [PW-1:0]              s2_p1_r, s2_p2_r;
  logic [NW-1:0]              quot, tgt_x;

  assign quot  = s1_prod_r[pds_pkg::SHIFT +: NW];
  assign tgt_x = NW'(tgt_r);

  // running best
  logic                       have_r;
  logic [NW-1:0]              min_err_r, best_q_r;
  logic [FW-1:0]              best_fb_r;
  logic [PW-1:0]              best_p1_r, best_p2_r;
  logic                       take;

  assign take = s2_vld_r && (!have_r || (s2_err_r < min_err_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = pds_pkg::EMPTY_RANGE ? ST_HOLD : ST_RUN;
      ST_RUN:   if (last_cand) state_nxt = ST_DRAIN;
      ST_DRAIN: if (s2_vld_r && s2_last_r) state_nxt = ST_HOLD;
      ST_HOLD:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      have_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      if (in_acc) begin
        have_r <= 1'b0;
      end else if (take) begin
        have_r <= 1'b1;
      end
    end
  end

  // counters, numerator accumulator and pipeline payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_r <= in_tdata[pds_pkg::TGT_W-1:0];
      fb_r  <= FW'(pds_pkg::FB_LOW);
      p1_r  <= PW'(1);
      p2_r  <= PW'(1);
      num_r <= NW'(base) * NW'(pds_pkg::FB_LOW);
    end else if (issue) begin
      // innermost loop is the second post divider
      if (p2_r == PW'(pds_pkg::POSTDIV_MAX)) begin
        p2_r <= PW'(1);
        if (p1_r == PW'(pds_pkg::POSTDIV_MAX)) begin
          p1_r  <= PW'(1);
          fb_r  <= fb_r + FW'(1);
          num_r <= num_r + NW'(base);
        end else begin
          p1_r <= p1_r + PW'(1);
        end
      end else begin
        p2_r <= p2_r + PW'(1);
      end
    end

    s1_prod_r <= prod;
    s1_fb_r   <= fb_r;
    s1_p1_r   <= p1_r;
    s1_p2_r   <= p2_r;
    s1_last_r <= last_cand;

    s2_q_r    <= quot;
    s2_err_r  <= (quot >= tgt_x) ? (quot - tgt_x) : (tgt_x - quot);
    s2_fb_r   <= s1_fb_r;
    s2_p1_r   <= s1_p1_r;
    s2_p2_r   <= s1_p2_r;
    s2_last_r <= s1_last_r;

    // defaults cover an empty range; first candidate always replaces them
    if (in_acc) begin
      best_fb_r <= FW'(pds_pkg::FB_LOW);
      best_p1_r <= PW'(1);
      best_p2_r <= PW'(1);
      best_q_r  <= '0;
    end else if (take) begin
      min_err_r  <= s2_err_r;
      best_q_r   <= s2_q_r;
      best_fb_r  <= s2_fb_r;
      best_p1_r  <= s2_p1_r;
      best_p2_r  <= s2_p2_r;
    end
  end

  // output register
  logic                          out_vld_r;
  logic [pds_pkg::OUT_DW-1:0]    out_data_r;
  logic [pds_pkg::FREQ_W-1:0]    freq_sat;
  logic                          load_out;

  localparam logic [NW-1:0] FREQ_MAX = NW'((64'd1 << pds_pkg::FREQ_W) - 64'd1);

  // saturate only matters if the numerator can outgrow the field
  assign freq_sat = (best_q_r > FREQ_MAX) ? {pds_pkg::FREQ_W{1'b1}}
                                          : pds_pkg::FREQ_W'(best_q_r);
  assign load_out = (state_r == ST_HOLD) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= pds_pkg::OUT_DW'({freq_sat,
                                      pds_pkg::PDO_W'(best_p2_r),
                                      pds_pkg::PDO_W'(best_p1_r),
                                      pds_pkg::FBO_W'(best_fb_r)});
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/pds_checker.sv
module pds_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [pds_pkg::OUT_DW-1:0]  out_tdata
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one search at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after acceptance");

  // a new result only comes out of a running search
  a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while idle");

  // dividers lie inside the searched range
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] >= 8'(pds_pkg::FB_LOW)) &&
                   (out_tdata[7:0] <= 8'(pds_pkg::FB_HIGH)) &&
                   (out_tdata[10:8] != 3'd0) && (out_tdata[13:11] != 3'd0))
    else $error("divider out of range");

endmodule

bind pll_divider_search_unit pds_checker u_pds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/pll_divider_search_checker.sv
`timescale 1ns / 100ps

module pll_divider_search_checker
  import pds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,    // [17:0] target_freq
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,   // [7:0] fb, [10:8] pd1, [13:11] pd2, [32:14] freq
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic [31:0]       cfg_prdata,
  input  logic              cfg_pready,
  output int                mismatch_count,
  output int                pending_count,
  output int                checked_count
);

  localparam longint unsigned FREQ_SAT = (64'd1 << FREQ_W) - 1;

  typedef struct packed {
    logic [FBO_W-1:0]  fb;
    logic [PDO_W-1:0]  pd1;
    logic [PDO_W-1:0]  pd2;
    logic [FREQ_W-1:0] freq;
  } divider_choice_t;

  divider_choice_t  expected_choices[$];
  logic [REF_W-1:0] ref_mhz;

  // exhaustive search, first candidate with the strictly smallest error wins
  function automatic divider_choice_t search_dividers(input logic [TGT_W-1:0] target,
                                                      input logic [REF_W-1:0] ref_clk);
    longint unsigned base;
    longint unsigned freq;
    longint unsigned err;
    longint unsigned min_err;
    longint unsigned best_freq;
    bit              found;
    divider_choice_t best;
    base      = 16 * ref_clk;
    best.fb   = FBO_W'(FB_LOW);
    best.pd1  = PDO_W'(1);
    best.pd2  = PDO_W'(1);
    best_freq = 0;
    min_err   = 0;
    found     = 1'b0;
    for (int unsigned fb = FB_LOW; fb <= FB_HIGH; fb++) begin
      for (int unsigned p1 = 1; p1 <= POSTDIV_MAX; p1++) begin
        for (int unsigned p2 = 1; p2 <= POSTDIV_MAX; p2++) begin
          freq = (base * fb) / (p1 * p2);
          err  = (freq >= target) ? freq - target : target - freq;
          if (!found || err < min_err) begin
            found     = 1'b1;
            min_err   = err;
            best.fb   = FBO_W'(fb);
            best.pd1  = PDO_W'(p1);
            best.pd2  = PDO_W'(p2);
            best_freq = freq;
          end
        end
      end
    end
    best.freq = (best_freq > FREQ_SAT) ? FREQ_W'(FREQ_SAT) : FREQ_W'(best_freq);
    return best;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    divider_choice_t got;
    divider_choice_t want;
    if (!rst_n) begin
      expected_choices.delete();
      ref_mhz        <= REF_W'(REF_RST);
      mismatch_count = 0;
      checked_count  = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite && cfg_paddr == REG_REF_CLK) begin
          ref_mhz <= cfg_pwdata[REF_W-1:0];
        end else if (!cfg_pwrite && cfg_paddr == REG_REF_CLK &&
                     cfg_prdata !== 32'(ref_mhz)) begin
          note_mismatch($sformatf("ref clock readback: expected %0d, got %0d",
                                  ref_mhz, cfg_prdata));
        end
      end
      if (in_tvalid && in_tready) begin
        expected_choices.push_back(search_dividers(in_tdata[TGT_W-1:0], ref_mhz));
      end
      if (out_tvalid && out_tready) begin
        got.fb   = out_tdata[FBO_W-1:0];
        got.pd1  = out_tdata[FBO_W +: PDO_W];
        got.pd2  = out_tdata[FBO_W+PDO_W +: PDO_W];
        got.freq = out_tdata[FBO_W+2*PDO_W +: FREQ_W];
        if (expected_choices.size() == 0) begin
          note_mismatch($sformatf("unexpected result: fb %0d pd1 %0d pd2 %0d freq %0d",
                                  got.fb, got.pd1, got.pd2, got.freq));
        end else begin
          want = expected_choices.pop_front();
          checked_count++;
          if (got !== want) begin
            note_mismatch({$sformatf("result %0d: expected fb %0d pd1 %0d pd2 %0d freq %0d",
                                     checked_count, want.fb, want.pd1, want.pd2,
                                     want.freq),
                           $sformatf(", got fb %0d pd1 %0d pd2 %0d freq %0d",
                                     got.fb, got.pd1, got.pd2, got.freq)});
          end
        end
      end
    end
    pending_count = expected_choices.size();
  end

endmodule

>>> tb/pll_divider_search_unit_test.sv
`timescale 1ns / 100ps

module pll_divider_search_unit_test;
  import pds_pkg::*;

  // a long hold-off must outlast two searches
  localparam int HOLD_CYCLES      = 12000;
  localparam int WATCHDOG_LIMIT   = 40000;
  localparam int SETTLE_CYCLES    = 20;
  localparam int RANDOM_PHASES    = 4;
  localparam int RANDOM_PER_PHASE = 32;
  localparam longint unsigned TGT_MAX = (64'd1 << TGT_W) - 1;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;    // [17:0] target_freq
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;   // [7:0] fb, [10:8] pd1, [13:11] pd2, [32:14] freq
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int mismatch_count;
  int pending_count;
  int checked_count;

  // knobs shared between the stimulus and the receiver
  bit send_fast;
  bit recv_fast;
  bit hold_out;

  int               words_sent;
  int               ref_settings;
  int               idle_cycles;
  logic [REF_W-1:0] ref_now;

  // directed targets at the reset reference clock: zero, all ones, single msb,
  // alternating bit patterns, exact hits at both ends of the range and a midpoint
  logic [TGT_W-1:0] reset_targets [10] = '{
    18'd0, 18'd1, 18'd262143, 18'd131072, 18'd87381,
    18'd174762, 18'd64000, 18'd95600, 18'd1306, 18'd64200
  };

  pll_divider_search_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pll_divider_search_checker divider_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog: cycles in which no word moves and the config port is quiet
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pll_divider_search_unit_test failed");
      $finish;
    end
  end

  // result side: wait for a word, stall at random (or the long hold-off once),
  // or in fast mode keep tready high throughout
  initial begin
    int unsigned stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!recv_fast) begin
        out_tready <= 1'b0;
        do @(posedge clk); while (out_tvalid !== 1'b1);
        if (hold_out) begin
          stall    = HOLD_CYCLES;
          hold_out = 1'b0;
        end else begin
          stall = $urandom_range(0, 9);
        end
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // offer one target word after a random gap (none if fast), return when it is taken
  task automatic offer_target(input logic [TGT_W-1:0] target);
    int unsigned gap;
    gap = send_fast ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DW'(target);
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // write the reference clock then read it back, only while the block is idle
  task automatic write_ref_clock(input logic [REF_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= REG_REF_CLK;
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // read setup follows the write access directly
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    ref_now = value;
    ref_settings++;
  endtask

  // mostly targets inside the reachable band, some exact candidate hits,
  // some anywhere in the 18-bit range and the two extremes
  function automatic logic [TGT_W-1:0] draw_target(input logic [REF_W-1:0] ref_clk);
    int unsigned     kind;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned hit;
    kind = $urandom_range(0, 9);
    lo   = (16 * ref_clk * FB_LOW) / (POSTDIV_MAX * POSTDIV_MAX);
    hi   = 16 * ref_clk * FB_HIGH;
    if (hi > TGT_MAX) hi = TGT_MAX;
    if (lo > hi) lo = hi;
    if (kind <= 6) begin
      return TGT_W'($urandom_range(32'(lo), 32'(hi)));
    end else if (kind == 7) begin
      return TGT_W'($urandom);
    end else if (kind == 8) begin
      return $urandom_range(0, 1) ? '1 : '0;
    end else begin
      hit = (16 * ref_clk * $urandom_range(FB_LOW, FB_HIGH)) /
            ($urandom_range(1, POSTDIV_MAX) * $urandom_range(1, POSTDIV_MAX));
      if (hit > TGT_MAX) hit = TGT_MAX;
      return TGT_W'(hit);
    end
  endfunction

  initial begin
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    send_fast    = 1'b0;
    recv_fast    = 1'b0;
    hold_out     = 1'b0;
    words_sent   = 0;
    ref_settings = 0;
    ref_now      = REF_W'(REF_RST);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset reference clock
    foreach (reset_targets[i]) offer_target(reset_targets[i]);
    drain_results();

    // zero reference clock: every candidate is 0, the first one wins
    write_ref_clock(REF_W'(0));
    offer_target(18'd0);
    offer_target(18'd12345);
    drain_results();

    // largest reference clock the register holds
    write_ref_clock(REF_W'(REF_MAXV));
    offer_target(18'd262143);
    offer_target(18'd200000);
    offer_target(18'd0);
    drain_results();

    // smallest and largest usable reference clocks
    write_ref_clock(REF_W'(1));
    offer_target(18'd0);
    offer_target(18'd2560);
    offer_target(18'd100);
    drain_results();

    write_ref_clock(REF_W'(100));
    offer_target(18'd262143);
    offer_target(18'd256000);
    offer_target(18'd1);
    drain_results();

    // random phases: first one holds the receiver off while the sender keeps
    // pushing, second runs with no idling on either side, the rest idle at random
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 2) begin
        write_ref_clock(REF_W'($urandom_range(0, REF_MAXV)));
      end else begin
        write_ref_clock(REF_W'($urandom_range(1, 100)));
      end
      send_fast = (phase <= 1);
      recv_fast = (phase == 1);
      hold_out  = (phase == 0);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) offer_target(draw_target(ref_now));
      drain_results();
      recv_fast = 1'b0;
      send_fast = 1'b0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d target words over %0d reference clock writes, %0d results checked",
             words_sent, ref_settings, checked_count);
    $display("included a %0d cycle receiver hold-off and full drains between settings",
             HOLD_CYCLES);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("pll_divider_search_unit_test passed");
    end else begin
      $display("pll_divider_search_unit_test failed");
    end
    $finish;
  end

endmodule
